### rtl/longest_ones_with_k_flips_macros.svh
// Assertion macros for the longest-ones window block.
// Included by the modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef LONGEST_ONES_WITH_K_FLIPS_MACROS_SVH
`define LONGEST_ONES_WITH_K_FLIPS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LOFK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LOFK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lofk_pkg.sv
// Package for the longest-ones window block: sizes, derived widths and port widths.
// Has no dependencies; used by longest_ones_with_k_flips.
package lofk_pkg;

  // Most elements per array and most zeros the window may hold.
  localparam int unsigned MaxLen   = 65536;
  localparam int unsigned MaxFlips = 64;

  // Derived widths.
  localparam int unsigned PosW  = $clog2(MaxLen + 1);
  localparam int unsigned ZposW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned SlotW = (MaxFlips > 1) ? $clog2(MaxFlips) : 1;
  localparam int unsigned SumW  = SlotW + 1;
  localparam int unsigned CntW  = $clog2(MaxFlips + 1);

  // Field and port widths.
  localparam int unsigned CfgW      = 7;
  localparam int unsigned LenW      = 17;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 40;

endpackage

### rtl/longest_ones_with_k_flips.sv
// Longest run of ones with up to K zero flips: the complete block in one module.
// Depends on lofk_pkg and longest_ones_with_k_flips_macros.svh.
//
// The result of an item appears in the cycle after its transaction, from an
// output register. Throughput: one item per cycle while the result stream is not
// stalled, set by the zero-position ring memory, whose entry for the next eviction
// is read ahead into a register with write forwarding. Reset clears all control
// state at once; the ring needs no clearing pass, so items are taken right after reset.
module longest_ones_with_k_flips (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: max_zeros.
  input  logic                          cfg_we_i,
  input  logic [lofk_pkg::CfgW-1:0]     cfg_wdata_i,
  // Input stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [lofk_pkg::InDataW-1:0]  s_axis_tdata_i,   // [0] bit_value, rest zero
  input  logic                          s_axis_tlast_i,   // last_item
  // Result stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [lofk_pkg::OutDataW-1:0] m_axis_tdata_o,   // [16:0] best_length,
                                                          // [33:17] window_length, rest zero
  output logic                          m_axis_tlast_o,   // final_result
  output logic                          m_axis_tuser_o    // overflow
);

  localparam int unsigned PosW  = lofk_pkg::PosW;
  localparam int unsigned ZposW = lofk_pkg::ZposW;
  localparam int unsigned SlotW = lofk_pkg::SlotW;
  localparam int unsigned SumW  = lofk_pkg::SumW;
  localparam int unsigned CntW  = lofk_pkg::CntW;
  localparam int unsigned LenW  = lofk_pkg::LenW;

  // Configuration register.
  logic [lofk_pkg::CfgW-1:0] max_zeros_q;

  // Window state.
  logic [PosW-1:0]  position_q, position_d;
  logic [PosW-1:0]  window_start_q, window_start_d;
  logic [CntW-1:0]  zeros_q, zeros_d;
  logic [SlotW-1:0] oldest_q, oldest_d;
  logic [PosW-1:0]  best_q, best_d;
  logic             overflow_q, overflow_d;

  // Ring of zero positions.
  logic [ZposW-1:0] ring_mem [lofk_pkg::MaxFlips];
  logic [ZposW-1:0] ring_rdata_q;
  logic             ring_we;
  logic [SlotW-1:0] ring_waddr;
  logic [ZposW-1:0] ring_wdata;

  // Output register.
  logic            out_valid_q;
  logic [LenW-1:0] out_best_q, out_wlen_q;
  logic            out_last_q, out_ovf_q;

  logic            in_acc;
  logic            bit_value;
  logic [CntW-1:0] k_lim;
  logic            evict;
  logic [SumW-1:0] slot_sum;
  logic [PosW-1:0] wlen;

  assign bit_value       = s_axis_tdata_i[0];
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (32'(max_zeros_q) < lofk_pkg::MaxFlips) begin
      k_lim = CntW'(max_zeros_q);
    end else begin
      k_lim = CntW'(lofk_pkg::MaxFlips);
    end
  end

  // The slot after the newest zero; the ring never holds more than its depth.
  always_comb begin
    slot_sum = {1'b0, oldest_q} + SumW'(zeros_q);
    if (slot_sum >= SumW'(lofk_pkg::MaxFlips)) begin
      slot_sum = slot_sum - SumW'(lofk_pkg::MaxFlips);
    end
  end

  always_comb begin
    position_d     = position_q;
    window_start_d = window_start_q;
    zeros_d        = zeros_q;
    oldest_d       = oldest_q;
    best_d         = best_q;
    overflow_d     = overflow_q;
    ring_we        = 1'b0;
    ring_waddr     = slot_sum[SlotW-1:0];
    ring_wdata     = position_q[ZposW-1:0];
    evict          = 1'b0;
    wlen           = position_q - window_start_q;

    if (in_acc) begin
      if (position_q >= PosW'(lofk_pkg::MaxLen)) begin
        // The array is too long: the window stays where it is.
        overflow_d = 1'b1;
      end else begin
        if (!bit_value && (k_lim == '0)) begin
          zeros_d        = '0;
          window_start_d = position_q + PosW'(1);
        end else begin
          evict = bit_value ? (zeros_q > k_lim) : (zeros_q >= k_lim);
          if (evict) begin
            window_start_d = PosW'(ring_rdata_q) + PosW'(1);
            oldest_d       = (oldest_q == SlotW'(lofk_pkg::MaxFlips - 1)) ?
                             '0 : oldest_q + SlotW'(1);
          end
          // The new zero lands in the same slot whether or not one was evicted.
          ring_we = !bit_value;
          zeros_d = zeros_q - CntW'(evict) + CntW'(!bit_value);
        end
        wlen       = position_q + PosW'(1) - window_start_d;
        position_d = position_q + PosW'(1);
        if (wlen > best_q) begin
          best_d = wlen;
        end
      end

      if (s_axis_tlast_i) begin
        position_d     = '0;
        window_start_d = '0;
        zeros_d        = '0;
        oldest_d       = '0;
        best_d         = '0;
        overflow_d     = 1'b0;
      end
    end
  end

  // The read address is the next oldest slot, so its entry is ready when the
  // next item arrives. A write to that slot in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (ring_we && (ring_waddr == oldest_d)) begin
      ring_rdata_q <= ring_wdata;
    end else begin
      ring_rdata_q <= ring_mem[oldest_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_zeros_q    <= '0;
      position_q     <= '0;
      window_start_q <= '0;
      zeros_q        <= '0;
      oldest_q       <= '0;
      best_q         <= '0;
      overflow_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_zeros_q <= cfg_wdata_i;
      end
      position_q     <= position_d;
      window_start_q <= window_start_d;
      zeros_q        <= zeros_d;
      oldest_q       <= oldest_d;
      best_q         <= best_d;
      overflow_q     <= overflow_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; the best length is taken before the end-of-array clear.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_best_q <= LenW'((wlen > best_q && position_q < PosW'(lofk_pkg::MaxLen)) ?
                          wlen : best_q);
      out_wlen_q <= LenW'(wlen);
      out_last_q <= s_axis_tlast_i;
      out_ovf_q  <= overflow_q || (position_q >= PosW'(lofk_pkg::MaxLen));
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(lofk_pkg::OutDataW - 2 * LenW)'(0), out_wlen_q, out_best_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

`include "longest_ones_with_k_flips_macros.svh"

  `LOFK_ASSERT_NOW(a_zeros_bound, 1'b1, zeros_q <= CntW'(lofk_pkg::MaxFlips), "ring count above depth")
  `LOFK_ASSERT_NOW(a_start_order, 1'b1, window_start_q <= position_q, "window start past position")
  `LOFK_ASSERT_NEXT(a_clear_on_last, in_acc && s_axis_tlast_i, (position_q == '0) && (zeros_q == '0) && !overflow_q, "state not cleared after last item")
  `LOFK_ASSERT_NEXT(a_pos_step, in_acc && !s_axis_tlast_i && (position_q < PosW'(lofk_pkg::MaxLen)), position_q == $past(position_q) + PosW'(1), "position did not advance")
  `LOFK_ASSERT_NEXT(a_result_follows, in_acc, m_axis_tvalid_o, "no result after accepted item")

endmodule

### sim/tb_longest_ones_with_k_flips.sv
// Self-checking testbench for longest_ones_with_k_flips: bit arrays in, window lengths out.
// Depends on lofk_pkg and the RTL of the block; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module tb_longest_ones_with_k_flips;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned RandomItems = 1500;
  localparam int unsigned ReportMax   = 10;

  typedef struct packed {
    logic [lofk_pkg::LenW-1:0] best_len;
    logic [lofk_pkg::LenW-1:0] win_len;
    logic                      final_flag;
    logic                      ovf;
  } window_result_t;

  // Tracks the sliding window of one array and holds the results still owed by the block.
  class window_checker;
    bit [lofk_pkg::CfgW-1:0] max_zeros;
    int unsigned    pos;
    int unsigned    win_start;
    int unsigned    zero_cnt;
    int unsigned    head_slot;
    int unsigned    longest;
    bit             ovf_seen;
    int unsigned    zero_pos [lofk_pkg::MaxFlips];
    window_result_t expected_windows [$];
    int unsigned    mismatches;
    int unsigned    checked;

    function new();
      max_zeros  = '0;
      mismatches = 0;
      checked    = 0;
      clear_array();
    endfunction

    function void clear_array();
      pos       = 0;
      win_start = 0;
      zero_cnt  = 0;
      head_slot = 0;
      longest   = 0;
      ovf_seen  = 1'b0;
      foreach (zero_pos[i]) zero_pos[i] = 0;
    endfunction

    function void set_max_zeros(bit [lofk_pkg::CfgW-1:0] v);
      max_zeros = v;
    endfunction

    function void drop_oldest_zero();
      if (zero_cnt == 0) return;
      win_start = zero_pos[head_slot] + 1;
      head_slot = (head_slot + 1) % lofk_pkg::MaxFlips;
      zero_cnt--;
    endfunction

    function void take_bit(bit b, bit last);
      int unsigned    k;
      int unsigned    wlen;
      window_result_t r;
      k = (max_zeros < lofk_pkg::MaxFlips) ? max_zeros : lofk_pkg::MaxFlips;
      if (pos >= lofk_pkg::MaxLen) begin
        // Past the length limit the window is frozen and only the sticky flag moves.
        ovf_seen = 1'b1;
        wlen = pos - win_start;
      end else begin
        if (!b) begin
          if (k == 0) begin
            zero_cnt  = 0;
            win_start = pos + 1;
          end else begin
            if (zero_cnt >= k) drop_oldest_zero();
            zero_pos[(head_slot + zero_cnt) % lofk_pkg::MaxFlips] = pos;
            zero_cnt++;
          end
        end else if (zero_cnt > k) begin
          drop_oldest_zero();
        end
        wlen = pos + 1 - win_start;
        if (wlen > longest) longest = wlen;
        pos++;
      end
      r.best_len   = longest[lofk_pkg::LenW-1:0];
      r.win_len    = wlen[lofk_pkg::LenW-1:0];
      r.final_flag = last;
      r.ovf        = ovf_seen;
      expected_windows.push_back(r);
      if (last) clear_array();
    endfunction

    function void check_window(window_result_t got);
      window_result_t want;
      checked++;
      if (expected_windows.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: unexpected result best=%0d win=%0d last=%b ovf=%b", $realtime,
                   got.best_len, got.win_len, got.final_flag, got.ovf);
        return;
      end
      want = expected_windows.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: mismatch best=%0d/%0d win=%0d/%0d last=%b/%b ovf=%b/%b (exp/got)",
                   $realtime, want.best_len, got.best_len, want.win_len, got.win_len,
                   want.final_flag, got.final_flag, want.ovf, got.ovf);
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [lofk_pkg::CfgW-1:0]     cfg_wdata = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [lofk_pkg::InDataW-1:0]  s_tdata = '0;
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [lofk_pkg::OutDataW-1:0] m_tdata;
  logic                          m_tlast;
  logic                          m_tuser;

  window_checker sb;
  bit            gaps_on = 1'b1;
  int unsigned   cycles = 0;
  int unsigned   items_sent = 0;
  int unsigned   arrays_sent = 0;
  int unsigned   cfg_writes = 0;
  int unsigned   longest_array = 0;
  bit [lofk_pkg::CfgW-1:0] cur_limit = '0;

  longest_ones_with_k_flips u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_longest_ones_with_k_flips failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready)
      sb.check_window({m_tdata[lofk_pkg::LenW-1:0], m_tdata[2*lofk_pkg::LenW-1:lofk_pkg::LenW],
                       m_tlast, m_tuser});
  end

  // Result side: random back-pressure after every transaction.
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = gaps_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_bit(input bit b, input bit last);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(lofk_pkg::InDataW-1){1'b0}}, b};
    s_tlast  <= last;
    do @(posedge clk_i); while (!(s_tvalid && s_tready));
    sb.take_bit(b, last);
    items_sent++;
  endtask

  // Stops the input stream and waits until every owed result has been seen.
  task automatic drain();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (sb.expected_windows.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_max_zeros(input bit [lofk_pkg::CfgW-1:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_max_zeros(v);
    cur_limit = v;
    cfg_writes++;
  endtask

  task automatic send_array(input int unsigned len, input int unsigned zero_pct,
                            input bit lower_mid);
    for (int unsigned i = 0; i < len; i++) begin
      if (lower_mid && len > 1 && i == len / 2) begin
        drain();
        write_max_zeros(lofk_pkg::CfgW'($urandom_range(0, cur_limit)));
      end
      send_bit($urandom_range(0, 99) >= zero_pct, i == len - 1);
    end
    arrays_sent++;
    if (len > longest_array) longest_array = len;
  endtask

  task automatic send_pattern(input bit b [$]);
    foreach (b[i]) send_bit(b[i], i == b.size() - 1);
    arrays_sent++;
  endtask

  initial begin : stimulus
    int unsigned             random_goal;
    int unsigned             len;
    bit [lofk_pkg::CfgW-1:0] v;
    sb = new();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed arrays: no flips, a saturated limit, single eviction, one-element
    // arrays, and a limit lowered in the middle of an array.
    write_max_zeros(lofk_pkg::CfgW'(0));
    send_pattern('{1, 0, 1, 1, 0});
    drain();
    write_max_zeros(lofk_pkg::CfgW'(127));
    send_pattern('{0, 0, 1});
    drain();
    write_max_zeros(lofk_pkg::CfgW'(1));
    send_pattern('{1, 1, 0, 1, 0, 1, 1});
    send_pattern('{0});
    send_pattern('{1});
    drain();
    write_max_zeros(lofk_pkg::CfgW'(3));
    send_bit(0, 0);
    send_bit(0, 0);
    send_bit(0, 0);
    send_bit(1, 0);
    drain();
    write_max_zeros(lofk_pkg::CfgW'(1));
    send_pattern('{1, 1, 0, 1});

    // Random arrays, mostly short, with occasional limit changes between and inside them.
    random_goal = items_sent + RandomItems;
    while (items_sent < random_goal) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        drain();
        case ($urandom_range(0, 5))
          0: v = lofk_pkg::CfgW'(0);
          1: v = lofk_pkg::CfgW'(lofk_pkg::MaxFlips);
          2: v = lofk_pkg::CfgW'(127);
          3: v = lofk_pkg::CfgW'($urandom_range(1, 8));
          4: v = lofk_pkg::CfgW'($urandom_range(0, 127));
          default: v = lofk_pkg::CfgW'($urandom_range(1, lofk_pkg::MaxFlips - 1));
        endcase
        write_max_zeros(v);
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 40);
      send_array(len, $urandom_range(0, 100), $urandom_range(0, 7) == 0);
    end

    gaps_on = 1'b1;
    send_array(12, 40, 1'b0);

    drain();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d results from %0d arrays (%0d bits), %0d limit writes, longest %0d.",
             sb.checked, arrays_sent, items_sent, cfg_writes, longest_array);
    if (sb.mismatches == 0 && sb.expected_windows.size() == 0) begin
      $display("tb_longest_ones_with_k_flips passed");
    end else begin
      $display("Mismatches: %0d, results still owed: %0d", sb.mismatches,
               sb.expected_windows.size());
      $display("tb_longest_ones_with_k_flips failed");
    end
    $finish;
  end

endmodule
